// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, ignored while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/iuo_pkg.sv =====
// Constants shared by the interval union and overlap block
package iuo_pkg;
  localparam int MAX_INTERVALS = 1024;
  localparam int COORD_BITS    = 31;
  localparam int FIELD_BITS    = 31;
  localparam int ADDR_BITS     = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = ADDR_BITS + 1;
  localparam int IDX_BITS      = CNT_BITS + 1;
  localparam int POS_BITS      = COORD_BITS + 1;
  localparam int ENTRY_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS      = COORD_BITS + IDX_BITS;
  localparam int PCT_BITS      = 7;
  localparam int PROD_BITS     = SUM_BITS + PCT_BITS;
  localparam int KBITS         = $clog2(PCT_BITS);
  localparam logic [FIELD_BITS-1:0] OUT_MAX = {FIELD_BITS{1'b1}};
  localparam logic [PCT_BITS-1:0]   PCT_FULL = PCT_BITS'(100);
  localparam logic                  KIND_REGION = 1'b0;
  localparam logic                  KIND_READ   = 1'b1;
endpackage

// ===== hw/rtl/iuo_in_if.sv =====
// Input channel: one interval per transaction
interface iuo_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [iuo_pkg::FIELD_BITS-1:0]   start_pos;
  logic [iuo_pkg::FIELD_BITS-1:0]   end_pos;
  logic                             last_item;
  modport source (output valid, kind, start_pos, end_pos, last_item, input ready);
  modport sink   (input valid, kind, start_pos, end_pos, last_item, output ready);
endinterface

// ===== hw/rtl/iuo_out_if.sv =====
// Output channel: one job result per transaction
interface iuo_out_if;
  logic                             valid;
  logic                             ready;
  logic [iuo_pkg::FIELD_BITS-1:0]   region_length;
  logic [iuo_pkg::FIELD_BITS-1:0]   read_length;
  logic [iuo_pkg::FIELD_BITS-1:0]   overlap_length;
  logic [iuo_pkg::PCT_BITS-1:0]     percent_covered;
  logic                             overflow;
  modport source (output valid, region_length, read_length, overlap_length,
                  percent_covered, overflow, input ready);
  modport sink   (input valid, region_length, read_length, overlap_length,
                  percent_covered, overflow, output ready);
endinterface

// ===== hw/rtl/interval_union_overlap_core.sv =====
// Interval union and overlap core: loads intervals into two stores, then sweeps them.
// Intervals load at one transaction per cycle into two 1024-entry RAMs (one per kind).
// The transaction flagged last_item starts the job, during which no input is taken.
// Each union is found by repeated sweeps over the RAM. Each sweep picks, among the intervals
// that reach the lowest uncovered position, the one with the lowest clipped start, and of
// those the furthest end. The region set, the read set and both together are swept in
// turn. The overlap product is then formed, the percent division runs one quotient bit at a
// time and the output register is loaded.
// The result sits in an output register, so the next job loads while it waits.
// No clearing pass after reset.
`include "assert_macros.svh"
module interval_union_overlap_core (
  input  logic       clk,
  input  logic       rst,
  iuo_in_if.sink     intervals,
  iuo_out_if.source  results
);
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] PH_REGION = 2'd0;
  localparam logic [1:0] PH_READ   = 2'd1;
  localparam logic [1:0] PH_BOTH   = 2'd2;

  localparam int C = iuo_pkg::COORD_BITS;

  logic [2:0] state;
  logic [1:0] phase;
  logic [iuo_pkg::CNT_BITS-1:0] rc;
  logic [iuo_pkg::CNT_BITS-1:0] dc;
  logic ovf;
  logic [iuo_pkg::IDX_BITS-1:0] idx;
  logic [iuo_pkg::IDX_BITS-1:0] lo;
  logic [iuo_pkg::IDX_BITS-1:0] hi;
  logic [iuo_pkg::IDX_BITS-1:0] b_idx;
  logic rd_vld;
  logic rd_last;
  logic rd_sel;
  logic [iuo_pkg::ENTRY_BITS-1:0] rd_a;
  logic [iuo_pkg::ENTRY_BITS-1:0] rd_b;
  logic [iuo_pkg::ENTRY_BITS-1:0] mem_a [iuo_pkg::MAX_INTERVALS];
  logic [iuo_pkg::ENTRY_BITS-1:0] mem_b [iuo_pkg::MAX_INTERVALS];

  logic found;
  logic [iuo_pkg::POS_BITS-1:0] best_s;
  logic [C-1:0] best_e;
  logic [iuo_pkg::POS_BITS-1:0] pos;
  logic [iuo_pkg::SUM_BITS-1:0] sum;
  logic [iuo_pkg::SUM_BITS-1:0] rl;
  logic [iuo_pkg::SUM_BITS-1:0] dl;
  logic [iuo_pkg::SUM_BITS-1:0] cl;
  logic [iuo_pkg::SUM_BITS-1:0] ov;
  logic [iuo_pkg::PROD_BITS-1:0] rem;
  logic [iuo_pkg::KBITS-1:0] k;
  logic [iuo_pkg::PCT_BITS-1:0] q;

  logic acc;
  logic [C-1:0] in_s;
  logic [C-1:0] in_e;
  logic in_ok;
  logic wr_a;
  logic wr_b;
  logic issue;
  logic [iuo_pkg::ENTRY_BITS-1:0] word;
  logic [C-1:0] w_s;
  logic [C-1:0] w_e;
  logic [iuo_pkg::POS_BITS-1:0] w_sp;
  logic better;
  logic [iuo_pkg::PROD_BITS-1:0] div_sub;
  logic [iuo_pkg::PCT_BITS-1:0] pct;
  logic out_load;

  // Input decode and store selection
  assign intervals.ready = (state == S_LOAD);
  assign acc   = intervals.valid && intervals.ready;
  assign in_s  = C'(intervals.start_pos);
  assign in_e  = C'(intervals.end_pos);
  assign in_ok = (in_e >= in_s);
  assign wr_a  = acc && in_ok && (intervals.kind == iuo_pkg::KIND_REGION) &&
                 (rc < iuo_pkg::CNT_BITS'(iuo_pkg::MAX_INTERVALS));
  assign wr_b  = acc && in_ok && (intervals.kind == iuo_pkg::KIND_READ) &&
                 (dc < iuo_pkg::CNT_BITS'(iuo_pkg::MAX_INTERVALS));

  // Sweep range per phase: region entries, read entries, then both
  always_comb begin
    case (phase)
      PH_REGION: begin
        lo = '0;
        hi = iuo_pkg::IDX_BITS'(rc);
      end
      PH_READ: begin
        lo = iuo_pkg::IDX_BITS'(rc);
        hi = iuo_pkg::IDX_BITS'(rc) + iuo_pkg::IDX_BITS'(dc);
      end
      default: begin
        lo = '0;
        hi = iuo_pkg::IDX_BITS'(rc) + iuo_pkg::IDX_BITS'(dc);
      end
    endcase
  end

  assign issue = (state == S_SCAN) && (idx < hi);
  assign b_idx = idx - iuo_pkg::IDX_BITS'(rc);

  // Interval RAMs, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[rc[iuo_pkg::ADDR_BITS-1:0]] <= {in_s, in_e};
    end
    rd_a <= mem_a[idx[iuo_pkg::ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[dc[iuo_pkg::ADDR_BITS-1:0]] <= {in_s, in_e};
    end
    rd_b <= mem_b[b_idx[iuo_pkg::ADDR_BITS-1:0]];
  end

  // Candidate test: lowest clipped start at or past pos, then longest end
  assign word   = rd_sel ? rd_b : rd_a;
  assign w_s    = word[iuo_pkg::ENTRY_BITS-1:C];
  assign w_e    = word[C-1:0];
  assign w_sp   = ({1'b0, w_s} > pos) ? {1'b0, w_s} : pos;
  assign better = ({1'b0, w_e} >= pos) &&
                  (!found || (w_sp < best_s) || ((w_sp == best_s) && (w_e > best_e)));

  // Division step and percent
  assign div_sub = iuo_pkg::PROD_BITS'(rl) << k;
  always_comb begin
    if ((rl == '0) || (dc == '0)) begin
      pct = '0;
    end else if (q > iuo_pkg::PCT_FULL) begin
      pct = iuo_pkg::PCT_FULL;
    end else begin
      pct = q;
    end
  end

  // Output register takes a new result
  assign out_load = (state == S_OUT) && (!results.valid || results.ready);

  // Read pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      rd_sel  <= 1'b0;
    end else begin
      rd_vld  <= issue;
      rd_last <= issue && (idx == hi - 1'b1);
      rd_sel  <= (idx >= iuo_pkg::IDX_BITS'(rc));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      phase         <= PH_REGION;
      rc            <= '0;
      dc            <= '0;
      ovf           <= 1'b0;
      found         <= 1'b0;
      idx           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && !out_load) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (acc) begin
            if (wr_a) begin
              rc <= rc + 1'b1;
            end
            if (wr_b) begin
              dc <= dc + 1'b1;
            end
            if (in_ok && !wr_a && !wr_b) begin
              ovf <= 1'b1;
            end
            if (intervals.last_item) begin
              state <= S_SETUP;
              phase <= PH_REGION;
              sum   <= '0;
              pos   <= '0;
            end
          end
        end
        S_SETUP: begin
          found <= 1'b0;
          idx   <= lo;
          state <= (lo == hi) ? S_STEP : S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (rd_vld && better) begin
            found  <= 1'b1;
            best_s <= w_sp;
            best_e <= w_e;
          end
          if (rd_vld && rd_last) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (found) begin
            sum   <= sum + iuo_pkg::SUM_BITS'({1'b0, best_e} - best_s + 1'b1);
            pos   <= {1'b0, best_e} + 1'b1;
            state <= S_SETUP;
          end else begin
            case (phase)
              PH_REGION: rl <= sum;
              PH_READ:   dl <= sum;
              default:   cl <= sum;
            endcase
            sum <= '0;
            pos <= '0;
            if (phase == PH_BOTH) begin
              state <= S_MUL;
            end else begin
              phase <= phase + 1'b1;
              state <= S_SETUP;
            end
          end
        end
        S_MUL: begin
          ov    <= rl + dl - cl;
          rem   <= iuo_pkg::PROD_BITS'(rl + dl - cl) * iuo_pkg::PROD_BITS'(100);
          k     <= iuo_pkg::KBITS'(iuo_pkg::PCT_BITS - 1);
          q     <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= div_sub) begin
            rem  <= rem - div_sub;
            q[k] <= 1'b1;
          end
          if (k == '0) begin
            state <= S_OUT;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            results.valid           <= 1'b1;
            results.region_length   <= (rl > iuo_pkg::SUM_BITS'(iuo_pkg::OUT_MAX)) ?
                                       iuo_pkg::OUT_MAX : iuo_pkg::FIELD_BITS'(rl);
            results.read_length     <= (dl > iuo_pkg::SUM_BITS'(iuo_pkg::OUT_MAX)) ?
                                       iuo_pkg::OUT_MAX : iuo_pkg::FIELD_BITS'(dl);
            results.overlap_length  <= (ov > iuo_pkg::SUM_BITS'(iuo_pkg::OUT_MAX)) ?
                                       iuo_pkg::OUT_MAX : iuo_pkg::FIELD_BITS'(ov);
            results.percent_covered <= pct;
            results.overflow        <= ovf;
            rc    <= '0;
            dc    <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_CLK(a_cnt_cap, clk, rst, (rc <= iuo_pkg::CNT_BITS'(iuo_pkg::MAX_INTERVALS)) && (dc <= iuo_pkg::CNT_BITS'(iuo_pkg::MAX_INTERVALS)), "store count past capacity")
  `ASSERT_CLK(a_last_stops, clk, rst, (acc && intervals.last_item) |=> !intervals.ready, "input taken after last transaction")
  `ASSERT_CLK(a_pct_range, clk, rst, results.valid |-> (results.percent_covered <= iuo_pkg::PCT_FULL), "percent above full")
  `ASSERT_CLK(a_rd_in_scan, clk, rst, rd_vld |-> (state == S_SCAN), "read data outside sweep")
endmodule
